### sv/bgc_pkg.sv
// Shared types and codes for the button gesture classifier.
// Used by bgc_cfg, bgc_fsm and button_gesture_classifier.
package bgc_pkg;

  localparam int DEBOUNCE_W = 20;
  localparam int LONG_W     = 24;
  localparam int WINDOW_W   = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 20'd30000;
  localparam logic [LONG_W-1:0]     LONG_RST     = 24'd800000;
  localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 24'd350000;

  // Gesture modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PRESSED = 2'd1;
  localparam logic [1:0] MODE_WAIT    = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_time;
    logic [LONG_W-1:0]     long_press_time;
    logic [WINDOW_W-1:0]   double_click_window;
  } bgc_cfg_t;

endpackage

### sv/bgc_cfg.sv
// Configuration register file for the button gesture classifier.
// Depends on bgc_pkg for register indexes, reset values and bgc_cfg_t.
module bgc_cfg import bgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output bgc_cfg_t              cfg
);

  bgc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= DEBOUNCE_RST;
      cfg_r.long_press_time     <= LONG_RST;
      cfg_r.double_click_window <= WINDOW_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE: cfg_r.debounce_time       <= wr_data[DEBOUNCE_W-1:0];
        REG_LONG:     cfg_r.long_press_time     <= wr_data[LONG_W-1:0];
        REG_WINDOW:   cfg_r.double_click_window <= wr_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/bgc_fsm.sv
// Gesture state machine: debounce, mode tracking and event decision for one poll.
// Depends on bgc_pkg for mode and event codes and bgc_cfg_t.
module bgc_fsm import bgc_pkg::*; #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  bgc_cfg_t              cfg,
  input  logic                  command,
  input  logic                  pressed,
  input  logic [TIME_WIDTH-1:0] edge_time,
  input  logic [TIME_WIDTH-1:0] now_time,
  output logic [1:0]            event_res
);

  logic [1:0]            mode_r, mode_nxt, mode_cur;
  logic [TIME_WIDTH-1:0] press_start_r, press_start_nxt;
  logic [TIME_WIDTH-1:0] release_r, release_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r, last_edge_nxt;

  logic [TIME_WIDTH-1:0] d_last, d_press, d_rel;
  logic [TIME_WIDTH-1:0] debounce_ext, long_ext, window_ext;
  logic                  bounce, done;

  assign debounce_ext = {{(TIME_WIDTH-DEBOUNCE_W){1'b0}}, cfg.debounce_time};
  assign long_ext     = {{(TIME_WIDTH-LONG_W){1'b0}}, cfg.long_press_time};
  assign window_ext   = {{(TIME_WIDTH-WINDOW_W){1'b0}}, cfg.double_click_window};

  // Wrapping differences
  assign d_last  = edge_time - last_edge_r;
  assign d_press = edge_time - press_start_r;
  assign bounce  = command && (d_last < debounce_ext);

  assign mode_cur = (mode_r == MODE_PRESSED || mode_r == MODE_WAIT) ? mode_r : MODE_IDLE;

  always_comb begin
    mode_nxt        = mode_cur;
    press_start_nxt = press_start_r;
    release_nxt     = release_r;
    last_edge_nxt   = last_edge_r;
    event_res       = EV_NONE;
    done            = bounce;
    if (command && !bounce) begin
      last_edge_nxt = edge_time;
      if (pressed) begin
        case (mode_cur)
          MODE_IDLE: begin
            press_start_nxt = edge_time;
            mode_nxt        = MODE_PRESSED;
          end
          MODE_WAIT: begin
            mode_nxt  = MODE_IDLE;
            event_res = EV_DOUBLE;
            done      = 1'b1;
          end
          default: ;
        endcase
      end else if (mode_cur == MODE_PRESSED) begin
        if (d_press >= long_ext) begin
          mode_nxt  = MODE_IDLE;
          event_res = EV_LONG;
          done      = 1'b1;
        end else begin
          release_nxt = edge_time;
          mode_nxt    = MODE_WAIT;
        end
      end
    end
    d_rel = now_time - release_nxt;
    // Window timeout uses the release stamp as updated by this poll
    if (!done && mode_nxt == MODE_WAIT && d_rel >= window_ext) begin
      mode_nxt  = MODE_IDLE;
      event_res = EV_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      press_start_r <= '0;
      release_r     <= '0;
      last_edge_r   <= '0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      press_start_r <= press_start_nxt;
      release_r     <= release_nxt;
      last_edge_r   <= last_edge_nxt;
    end
  end

  a_double_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_res == EV_DOUBLE |-> mode_r == MODE_WAIT)
    else $error("double click outside the wait mode");

  a_event_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_res != EV_NONE |=> mode_r == MODE_IDLE)
    else $error("mode not idle after an event");

  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r) && $stable(last_edge_r))
    else $error("state changed without a poll");

  a_bounce_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step && bounce |-> event_res == EV_NONE)
    else $error("event on a bounced edge");

endmodule

### sv/button_gesture_classifier.sv
// Top level of the button gesture classifier: input and result registers.
// Depends on bgc_pkg, bgc_cfg and bgc_fsm.
//
// Takes one poll per clock and gives exactly one event per poll. A poll is
// captured in the input register, decided by the gesture state machine
// against its mode and stored timestamps once the result register is free,
// and written to the result register, from which it is offered. Sustained
// rate is one poll per cycle, limited only by the result side: a stalled
// result holds the input register, which then stalls the input channel.
// Configuration writes are always ready and should be made only while no
// poll is in flight.
module button_gesture_classifier import bgc_pkg::*; #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic                  in_pressed,
  input  logic [TIME_WIDTH-1:0] in_edge_time,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  in_vld_r;
  logic                  cmd_r, pressed_r;
  logic [TIME_WIDTH-1:0] edge_r, now_r;
  logic                  out_vld_r;
  logic [1:0]            ev_r;
  logic [1:0]            ev;
  logic                  advance, step;
  bgc_cfg_t              cfg;

  assign cfg_ready = 1'b1;

  // Result slot frees when empty or taken this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  bgc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bgc_fsm #(.TIME_WIDTH(TIME_WIDTH)) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg),
    .command   (cmd_r),
    .pressed   (pressed_r),
    .edge_time (edge_r),
    .now_time  (now_r),
    .event_res (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r     <= in_command;
      pressed_r <= in_pressed;
      edge_r    <= in_edge_time;
      now_r     <= in_now_time;
    end
    if (step) begin
      ev_r <= ev;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_event_res = ev_r;

endmodule

### sim/button_gesture_classifier_test.sv
// Self-checking bench for button_gesture_classifier: directed and random polls, gestures,
// each event checked against an in-bench gesture tracker under several register settings.
// Depends on bgc_pkg and the button_gesture_classifier RTL.
module button_gesture_classifier_test import bgc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 48;
  localparam logic [TW-1:0] TOP = {TW{1'b1}};

  typedef struct {
    bit            command;
    bit            pressed;
    logic [TW-1:0] edge_time;
    logic [TW-1:0] now_time;
  } poll_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = 1'b0;
  logic                  in_pressed = 1'b0;
  logic [TW-1:0]         in_edge_time = '0;
  logic [TW-1:0]         in_now_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_event_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Gesture tracker state and its copy of the registers
  logic [1:0]            trk_mode;
  logic [TW-1:0]         trk_press_start;
  logic [TW-1:0]         trk_release;
  logic [TW-1:0]         trk_last_edge;
  logic [DEBOUNCE_W-1:0] cfg_debounce;
  logic [LONG_W-1:0]     cfg_long;
  logic [WINDOW_W-1:0]   cfg_window;

  poll_t         pending_polls[$];
  logic [1:0]    events_due[$];
  poll_t         on_wire;
  logic [TW-1:0] wall_clock;
  int unsigned   in_gap = 0;
  int unsigned   stall_left = 0;
  int            polls_taken = 0;
  int            errors = 0;
  bit            steady = 1'b0;
  logic          stall_hold = 1'b0;

  button_gesture_classifier #(.TIME_WIDTH(TW)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_pressed   (in_pressed),
    .in_edge_time (in_edge_time),
    .in_now_time  (in_now_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] classify_poll(poll_t p);
    logic [1:0] ev;
    ev = EV_NONE;
    if (p.command) begin
      // drop bounced edges, and skip the window check with them
      if ((p.edge_time - trk_last_edge) < TW'(cfg_debounce)) return EV_NONE;
      trk_last_edge = p.edge_time;
      if (p.pressed) begin
        if (trk_mode == MODE_IDLE) begin
          trk_press_start = p.edge_time;
          trk_mode = MODE_PRESSED;
        end else if (trk_mode == MODE_WAIT) begin
          trk_mode = MODE_IDLE;
          return EV_DOUBLE;
        end
      end else if (trk_mode == MODE_PRESSED) begin
        if ((p.edge_time - trk_press_start) >= TW'(cfg_long)) begin
          trk_mode = MODE_IDLE;
          return EV_LONG;
        end
        trk_release = p.edge_time;
        trk_mode = MODE_WAIT;
      end
    end
    if (trk_mode == MODE_WAIT && (p.now_time - trk_release) >= TW'(cfg_window)) begin
      trk_mode = MODE_IDLE;
      ev = EV_SINGLE;
    end
    return ev;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Driver: present queued polls, predict each one on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        events_due.push_back(classify_poll(on_wire));
        polls_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_polls.size() > 0) begin
          on_wire = pending_polls.pop_front();
          in_command <= on_wire.command;
          in_pressed <= on_wire.pressed;
          in_edge_time <= on_wire.edge_time;
          in_now_time <= on_wire.now_time;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each event transfer, stall the result side at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          flag_mismatch($sformatf("event %0d with no poll pending", out_event_res));
        end else if (out_event_res !== events_due[0]) begin
          flag_mismatch($sformatf("event_res %0d, want %0d", out_event_res, events_due[0]));
          void'(events_due.pop_front());
        end else begin
          void'(events_due.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_hold) begin
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Hold the result side off long enough to back the block up into its input
  initial begin
    wait (polls_taken >= 180);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (60) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("[button_gesture_classifier] ERROR");
    $finish;
  end

  task automatic add_poll(bit cmd, bit lvl, logic [TW-1:0] et, logic [TW-1:0] now);
    poll_t p;
    p.command = cmd;
    p.pressed = lvl;
    p.edge_time = et;
    p.now_time = now;
    pending_polls.push_back(p);
  endtask

  task automatic add_edge(bit lvl, int unsigned step);
    wall_clock += TW'(step);
    add_poll(1'b1, lvl, wall_clock, wall_clock + TW'($urandom_range(0, 40)));
  endtask

  // Plain poll; the unused edge fields carry noise
  task automatic add_wait(int unsigned step);
    wall_clock += TW'(step);
    add_poll(1'b0, 1'($urandom), TW'({$urandom, $urandom}), wall_clock);
  endtask

  task automatic add_gesture();
    int unsigned r;
    int unsigned hold;
    int unsigned apart;
    int unsigned deb;
    int unsigned lng;
    int unsigned win;
    deb = 32'(cfg_debounce);
    lng = 32'(cfg_long);
    win = 32'(cfg_window);
    hold = deb + $urandom_range(1, 500);
    apart = deb + $urandom_range(1, 3000);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      add_edge(1'b1, apart);
      add_edge(1'b0, hold);
      if ($urandom_range(0, 1)) add_wait($urandom_range(0, win / 2));
      add_wait(win + $urandom_range(0, 100));
    end else if (r < 50) begin
      add_edge(1'b1, apart);
      add_edge(1'b0, hold);
      add_edge(1'b1, deb + $urandom_range(1, 200));
      add_edge(1'b0, hold);
    end else if (r < 70) begin
      add_edge(1'b1, apart);
      add_wait($urandom_range(0, lng / 2));
      add_edge(1'b0, lng + deb + $urandom_range(0, 1000));
    end else if (r < 80) begin
      add_edge(1'($urandom), $urandom_range(0, deb));
    end else if (r < 88) begin
      add_edge(1'($urandom), apart);
    end else begin
      add_poll(1'($urandom), 1'($urandom), TW'({$urandom, $urandom}),
               TW'({$urandom, $urandom}));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = val[DEBOUNCE_W-1:0];
      REG_LONG:     cfg_long = val[LONG_W-1:0];
      REG_WINDOW:   cfg_window = val[WINDOW_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_polls.size() != 0 || in_valid || events_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase;
    int unsigned target;
    trk_mode = MODE_IDLE;
    trk_press_start = '0;
    trk_release = '0;
    trk_last_edge = '0;
    cfg_debounce = DEBOUNCE_RST;
    cfg_long = LONG_RST;
    cfg_window = WINDOW_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed gestures under the reset settings
    add_poll(1'b0, 1'b0, '0, '0);
    add_poll(1'b1, 1'b1, 48'd1000, 48'd1000);
    add_poll(1'b1, 1'b1, 48'd100000, 48'd100010);
    add_poll(1'b1, 1'b1, 48'd200000, 48'd200000);
    add_poll(1'b1, 1'b0, 48'd300000, 48'd300000);
    add_poll(1'b1, 1'b0, 48'd400000, 48'd400000);
    add_poll(1'b0, 1'b0, '0, 48'd500000);
    add_poll(1'b0, 1'b1, TOP, 48'd650000);
    add_poll(1'b1, 1'b0, 48'd700000, 48'd700000);
    add_poll(1'b1, 1'b1, 48'd710000, 48'd710000);
    add_poll(1'b1, 1'b1, 48'd800000, 48'd800000);
    add_poll(1'b1, 1'b0, 48'd1600000, 48'd1600000);
    add_poll(1'b1, 1'b1, 48'd2000000, 48'd2000000);
    add_poll(1'b1, 1'b0, 48'd2100000, 48'd2100000);
    add_poll(1'b1, 1'b1, 48'd2200000, 48'd2200000);
    add_poll(1'b1, 1'b1, 48'd3000000, 48'd3000000);
    add_poll(1'b1, 1'b0, 48'd3100000, 48'd3100000);
    add_poll(1'b1, 1'b1, 48'd3110000, 48'd9000000);
    add_poll(1'b0, 1'b0, '0, 48'd9000000);
    // Hold across the wrap of the time counter
    add_poll(1'b1, 1'b1, TOP - 48'd99999, TOP - 48'd99999);
    add_poll(1'b1, 1'b0, 48'd200000, 48'd200000);
    add_poll(1'b0, 1'b0, '0, TOP);
    add_poll(1'b1, 1'b1, TOP, '0);
    add_poll(1'b1, 1'b0, TOP - 48'd50000, TOP);
    wait_idle();

    wall_clock = 48'd20000000;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DEBOUNCE, '0);
          write_reg(REG_LONG, '0);
          write_reg(REG_WINDOW, '0);
        end
        1: begin
          write_reg(REG_DEBOUNCE, 24'd1000000);
          write_reg(REG_LONG, 24'd10000000);
          write_reg(REG_WINDOW, 24'd10000000);
        end
        2: begin
          write_reg(REG_DEBOUNCE, 24'd50);
          write_reg(REG_LONG, 24'd2000);
          write_reg(REG_WINDOW, 24'd700);
        end
        3: begin
          write_reg(REG_DEBOUNCE, 24'(DEBOUNCE_RST));
          write_reg(REG_LONG, 24'(LONG_RST));
          write_reg(REG_WINDOW, 24'(WINDOW_RST));
        end
        default: begin
          write_reg(REG_DEBOUNCE, 24'($urandom_range(0, 1000000)));
          write_reg(REG_LONG, 24'($urandom_range(0, 10000000)));
          write_reg(REG_WINDOW, 24'($urandom_range(0, 10000000)));
        end
      endcase
      // Run one phase without any idling on either side
      steady = (phase == 3);
      target = pending_polls.size() + 80;
      while (pending_polls.size() < target) add_gesture();
      wait_idle();
    end

    if (errors == 0) begin
      $display("[button_gesture_classifier] OK");
    end else begin
      $display("[button_gesture_classifier] ERROR");
    end
    $finish;
  end

endmodule
